### src/iss_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// iss_pkg
// Shared constants for the indexed sequence store: default depth, data width,
// command codes, status codes and the read miss value.
// ----------------------------------------------------------------------------
package iss_pkg;

  localparam int unsigned DEPTH_DEF = 1024;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned CMD_W     = 3;
  localparam int unsigned STATUS_W  = 2;

  // command codes
  localparam logic [CMD_W-1:0] CMD_READ     = 3'd0;
  localparam logic [CMD_W-1:0] CMD_ADD_HEAD = 3'd1;
  localparam logic [CMD_W-1:0] CMD_ADD_TAIL = 3'd2;
  localparam logic [CMD_W-1:0] CMD_INSERT   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_DELETE   = 3'd4;

  // status codes
  localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  // read value reported on a read miss
  localparam logic [DATA_W-1:0] MISS_VALUE = '1;

endpackage
`default_nettype wire

### src/indexed_sequence_store.sv
`default_nettype none
// ----------------------------------------------------------------------------
// indexed_sequence_store
// Ordered sequence of signed 32-bit values with read, add at head, add at
// tail, insert and delete at an index. Entries live in one synchronous RAM;
// insert and delete move the later entries one slot per cycle.
//
//   channel | ports                                        | direction
//   --------+----------------------------------------------+----------
//   in      | in_valid, in_stall, in_command, in_position, | request in
//           | in_item_value                                |
//   out     | out_valid, out_stall, out_read_value,        | result out
//           | out_status, out_length_now                   |
//
// Insert and delete take longer as more entries lie past the position; the
// single RAM read port moves one entry per cycle. One request is in work at
// a time; a new request is taken while the previous result still waits on
// out_stall.
// Reset clears the length and control state; RAM contents are not cleared.
// ----------------------------------------------------------------------------
module indexed_sequence_store
  import iss_pkg::*;
#(
  parameter int unsigned DEPTH  = DEPTH_DEF,
  localparam int unsigned LEN_W = $clog2(DEPTH + 1),
  localparam int unsigned AW    = $clog2(DEPTH)
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire logic [CMD_W-1:0]         in_command,
  input  wire logic [LEN_W-1:0]         in_position,
  input  wire logic signed [DATA_W-1:0] in_item_value,
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output logic signed [DATA_W-1:0]      out_read_value,
  output logic [STATUS_W-1:0]           out_status,
  output logic [LEN_W-1:0]              out_length_now
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_READ  = 2'd1;
  localparam logic [1:0] S_SHIFT = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  localparam logic [LEN_W-1:0] FULL_LEN = LEN_W'(DEPTH);

  // control state
  logic [1:0]       state_r, state_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;
  logic [LEN_W-1:0] cnt_r, cnt_nxt;
  logic [AW-1:0]    cur_r, cur_nxt;
  logic             mv_r, mv_nxt;
  logic             out_valid_r, out_valid_nxt;

  // request and result payload
  logic [AW-1:0]          mv_addr_r, mv_addr_nxt;
  logic                   op_ins_r, op_ins_nxt;
  logic [AW-1:0]          pos_r, pos_nxt;
  logic [DATA_W-1:0]      val_r, val_nxt;
  logic [DATA_W-1:0]      res_rd_r, res_rd_nxt;
  logic [STATUS_W-1:0]    res_st_r, res_st_nxt;
  logic [DATA_W-1:0]      out_rd_r, out_rd_nxt;
  logic [STATUS_W-1:0]    out_st_r, out_st_nxt;
  logic [LEN_W-1:0]       out_len_r, out_len_nxt;

  // RAM port
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [DATA_W-1:0] wr_data;
  logic [AW-1:0]     rd_addr;
  logic [DATA_W-1:0] rd_data;

  // helpers
  logic             accept;
  logic [LEN_W-1:0] ins_pos;
  logic             ins_ok;
  logic [LEN_W-1:0] len_m1;
  logic [LEN_W-1:0] pos_p1;

  iss_ram #(
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign accept = in_valid && (state_r == S_IDLE);
  assign len_m1 = len_r - LEN_W'(1);
  assign pos_p1 = in_position + LEN_W'(1);

  // pick the insert slot and range check for the add family
  always_comb begin
    ins_pos = in_position;
    ins_ok  = 1'b1;
    case (in_command)
      CMD_ADD_HEAD: ins_pos = '0;
      CMD_ADD_TAIL: ins_pos = len_r;
      CMD_INSERT:   ins_ok  = (in_position <= len_r);
      default:      ins_pos = in_position;
    endcase
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    len_nxt       = len_r;
    cnt_nxt       = cnt_r;
    cur_nxt       = cur_r;
    mv_nxt        = 1'b0;
    mv_addr_nxt   = mv_addr_r;
    op_ins_nxt    = op_ins_r;
    pos_nxt       = pos_r;
    val_nxt       = val_r;
    res_rd_nxt    = res_rd_r;
    res_st_nxt    = res_st_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_rd_nxt    = out_rd_r;
    out_st_nxt    = out_st_r;
    out_len_nxt   = out_len_r;
    wr_en         = 1'b0;
    wr_addr       = mv_addr_r;
    wr_data       = rd_data;
    rd_addr       = in_position[AW-1:0];

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          res_rd_nxt = '0;
          res_st_nxt = ST_DONE;
          state_nxt  = S_DONE;
          case (in_command)
            CMD_READ: begin
              // fetch now; the read data is taken in S_READ
              if (in_position < len_r) begin
                state_nxt = S_READ;
              end else begin
                res_rd_nxt = MISS_VALUE;
                res_st_nxt = ST_RANGE;
              end
            end
            CMD_ADD_HEAD, CMD_ADD_TAIL, CMD_INSERT: begin
              if (!ins_ok) begin
                res_st_nxt = ST_RANGE;
              end else if (len_r == FULL_LEN) begin
                res_st_nxt = ST_FULL;
              end else if (ins_pos == len_r) begin
                // append: no entries to move
                wr_en   = 1'b1;
                wr_addr = len_r[AW-1:0];
                wr_data = in_item_value;
                len_nxt = len_r + LEN_W'(1);
              end else begin
                // move entries up, from the tail down to the slot
                cnt_nxt    = len_r - ins_pos;
                cur_nxt    = len_m1[AW-1:0];
                op_ins_nxt = 1'b1;
                pos_nxt    = ins_pos[AW-1:0];
                val_nxt    = in_item_value;
                state_nxt  = S_SHIFT;
              end
            end
            CMD_DELETE: begin
              if (in_position >= len_r) begin
                res_st_nxt = ST_RANGE;
              end else begin
                // move entries down, from just past the slot to the tail
                cnt_nxt    = len_m1 - in_position;
                cur_nxt    = pos_p1[AW-1:0];
                op_ins_nxt = 1'b0;
                state_nxt  = S_SHIFT;
              end
            end
            default: begin
              res_st_nxt = ST_DONE;
            end
          endcase
        end
      end

      S_READ: begin
        res_rd_nxt = rd_data;
        res_st_nxt = ST_DONE;
        state_nxt  = S_DONE;
      end

      S_SHIFT: begin
        rd_addr = cur_r;
        // write back the entry fetched last cycle
        if (mv_r) begin
          wr_en   = 1'b1;
          wr_addr = mv_addr_r;
          wr_data = rd_data;
        end
        if (cnt_r != '0) begin
          // fetch the next entry to move
          cnt_nxt     = cnt_r - LEN_W'(1);
          mv_nxt      = 1'b1;
          cur_nxt     = op_ins_r ? (cur_r - AW'(1)) : (cur_r + AW'(1));
          mv_addr_nxt = op_ins_r ? (cur_r + AW'(1)) : (cur_r - AW'(1));
        end else if (!mv_r) begin
          // all moved: drop in the new value or shrink
          if (op_ins_r) begin
            wr_en   = 1'b1;
            wr_addr = pos_r;
            wr_data = val_r;
            len_nxt = len_r + LEN_W'(1);
          end else begin
            len_nxt = len_m1;
          end
          res_rd_nxt = '0;
          res_st_nxt = ST_DONE;
          state_nxt  = S_DONE;
        end
      end

      S_DONE: begin
        // hand the result over once the output register is free
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_rd_nxt    = res_rd_r;
          out_st_nxt    = res_st_r;
          out_len_nxt   = len_r;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      len_r       <= '0;
      cnt_r       <= '0;
      cur_r       <= '0;
      mv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      len_r       <= len_nxt;
      cnt_r       <= cnt_nxt;
      cur_r       <= cur_nxt;
      mv_r        <= mv_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    mv_addr_r <= mv_addr_nxt;
    op_ins_r  <= op_ins_nxt;
    pos_r     <= pos_nxt;
    val_r     <= val_nxt;
    res_rd_r  <= res_rd_nxt;
    res_st_r  <= res_st_nxt;
    out_rd_r  <= out_rd_nxt;
    out_st_r  <= out_st_nxt;
    out_len_r <= out_len_nxt;
  end

  assign in_stall       = (state_r != S_IDLE);
  assign out_valid      = out_valid_r;
  assign out_read_value = out_rd_r;
  assign out_status     = out_st_r;
  assign out_length_now = out_len_r;

`ifndef ASSERT_OFF
  // length never passes capacity
  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= FULL_LEN)
    else $error("length exceeds capacity");

  // length holds while entries are still being moved
  a_len_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SHIFT) && (cnt_r != '0) |=> $stable(len_r))
    else $error("length changed during entry move");

  // a full refusal reports a full store
  a_full_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_st_r == ST_FULL) |-> (out_len_r == FULL_LEN))
    else $error("full status with store not full");

  // a read fetch always follows an accepted request
  a_read_src: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_READ) |-> $past(accept))
    else $error("read state entered without a request");
`endif

endmodule
`default_nettype wire

### src/iss_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// iss_ram
// Entry storage: one write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module iss_ram
  import iss_pkg::*;
#(
  parameter int unsigned DEPTH = DEPTH_DEF,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [AW-1:0]     wr_addr,
  input  wire logic [DATA_W-1:0] wr_data,
  input  wire logic [AW-1:0]     rd_addr,
  output logic      [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire
